// ===== hw/rtl/stepper_homing_position_controller_assert.svh =====
// Assertion macros for the stepper homing and position controller.
// Used by the top level; expects signals clk and arst_n in scope.
`ifndef STEPPER_HOMING_POSITION_CONTROLLER_ASSERT_SVH
`define STEPPER_HOMING_POSITION_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define SHPC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SHPC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/shpc_pkg.sv =====
// Package for the stepper homing and position controller.
// Holds widths, field codes, the phase type, the state/result structs and the phase_code mapping.
`timescale 1ns / 1ps

package shpc_pkg;

	localparam int POS_BITS = 16;
	localparam int OUT_POS_BITS = 16;
	localparam logic [7:0] OFFSET_RESET = 8'd12;

	localparam logic [1:0] MODE_TICK = 2'd0;
	localparam logic [1:0] MODE_TARGET = 2'd1;
	localparam logic [1:0] MODE_RECAL = 2'd2;

	localparam logic [1:0] DIR_NONE = 2'd0;
	localparam logic [1:0] DIR_LEFT = 2'd1;
	localparam logic [1:0] DIR_RIGHT = 2'd2;

	localparam logic [1:0] PHASE_CODE_CALIB = 2'd0;
	localparam logic [1:0] PHASE_CODE_OFFSET = 2'd1;
	localparam logic [1:0] PHASE_CODE_IDLE = 2'd2;
	localparam logic [1:0] PHASE_CODE_MOVING = 2'd3;

	typedef enum logic [3:0] {
		PH_CALIB = 4'b0001,
		PH_OFFSET = 4'b0010,
		PH_IDLE = 4'b0100,
		PH_MOVING = 4'b1000
	} phase_t;

	typedef struct packed {
		phase_t phase;
		logic [POS_BITS-1:0] cur_pos;
		logic [POS_BITS-1:0] des_pos;
	} ctrl_state_t;

	typedef struct packed {
		logic [1:0] step_dir;
		logic [1:0] phase;
		logic [OUT_POS_BITS-1:0] position;
	} result_t;

	function automatic logic [1:0] phase_code(input phase_t ph);
		logic [1:0] code;
		case (ph)
			PH_CALIB: code = PHASE_CODE_CALIB;
			PH_OFFSET: code = PHASE_CODE_OFFSET;
			PH_IDLE: code = PHASE_CODE_IDLE;
			PH_MOVING: code = PHASE_CODE_MOVING;
			default: code = PHASE_CODE_CALIB;
		endcase
		return code;
	endfunction

endpackage

// ===== hw/rtl/shpc_if.sv =====
// Valid/ready channel interfaces for the stepper controller items.
// Depends on shpc_pkg for field widths.
`timescale 1ns / 1ps

interface shpc_req_if;
	logic valid;
	logic ready;
	logic [1:0] mode;
	logic detector_active;
	logic [15:0] target_position;

	modport source(output valid, mode, detector_active, target_position, input ready);
	modport sink(input valid, mode, detector_active, target_position, output ready);
endinterface

interface shpc_rsp_if;
	logic valid;
	logic ready;
	logic [1:0] step_dir;
	logic [1:0] phase;
	logic [shpc_pkg::OUT_POS_BITS-1:0] position;

	modport source(output valid, step_dir, phase, position, input ready);
	modport sink(input valid, step_dir, phase, position, output ready);
endinterface

// ===== hw/rtl/shpc_step.sv =====
// Next-state and step logic for one item of the stepper controller.
// Depends on shpc_pkg.
`timescale 1ns / 1ps

module shpc_step (
	input logic [1:0] mode,
	input logic detector_active,
	input logic [15:0] target_position,
	input logic [7:0] offset_steps,
	input shpc_pkg::ctrl_state_t cur,
	output shpc_pkg::ctrl_state_t nxt,
	output logic [1:0] step_dir
);

	logic [shpc_pkg::POS_BITS-1:0] offset_ext;
	logic [shpc_pkg::POS_BITS-1:0] pos_inc;
	logic [shpc_pkg::POS_BITS-1:0] pos_dec;

	assign offset_ext = shpc_pkg::POS_BITS'(offset_steps);
	assign pos_inc = cur.cur_pos + shpc_pkg::POS_BITS'(1);
	assign pos_dec = cur.cur_pos - shpc_pkg::POS_BITS'(1);

	always_comb begin
		nxt = cur;
		step_dir = shpc_pkg::DIR_NONE;
		case (mode)
			shpc_pkg::MODE_TICK: begin
				case (cur.phase)
					shpc_pkg::PH_CALIB: begin
						if (detector_active) begin
							nxt.phase = shpc_pkg::PH_OFFSET;
							nxt.cur_pos = '0;
							nxt.des_pos = '0;
						end else begin
							step_dir = shpc_pkg::DIR_LEFT;
						end
					end
					shpc_pkg::PH_OFFSET: begin
						if (cur.cur_pos < offset_ext) begin
							step_dir = shpc_pkg::DIR_LEFT;
							nxt.cur_pos = pos_inc;
						end else begin
							nxt.phase = shpc_pkg::PH_IDLE;
							nxt.cur_pos = '0;
							nxt.des_pos = '0;
						end
					end
					shpc_pkg::PH_IDLE: begin
						if (cur.cur_pos != cur.des_pos) begin
							nxt.phase = shpc_pkg::PH_MOVING;
						end
					end
					default: begin
						if (cur.cur_pos > cur.des_pos) begin
							step_dir = shpc_pkg::DIR_RIGHT;
							nxt.cur_pos = pos_dec;
						end else if (cur.cur_pos < cur.des_pos) begin
							step_dir = shpc_pkg::DIR_LEFT;
							nxt.cur_pos = pos_inc;
						end else begin
							nxt.phase = shpc_pkg::PH_IDLE;
						end
					end
				endcase
			end
			shpc_pkg::MODE_TARGET: begin
				nxt.des_pos = shpc_pkg::POS_BITS'(target_position);
			end
			shpc_pkg::MODE_RECAL: begin
				nxt.phase = shpc_pkg::PH_CALIB;
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

// ===== hw/rtl/stepper_homing_position_controller.sv =====
// Stepper homing and position controller, top level.
// Depends on shpc_pkg, shpc_if, shpc_step and the assertion macro header.
//
// Usage:
//   req carries one item per handshake: mode (tick, set target, recalibrate),
//   detector_active and target_position. rsp returns exactly one item per
//   request item: step_dir, phase and position after that item.
//   cfg_we/cfg_wdata write offset_steps; write only while no item is in flight.
// Timing: the result item is registered and valid in the cycle after its request is accepted.
// Throughput: one item per cycle unless a pending result is stalled; the only loop is
//   the controller state register through the combinational next-state logic.
// Reset (arst_n low): phase calibrating, position and target zero,
//   offset_steps 12, no result pending.
// Stall: the result register holds while rsp.ready is low; req.ready stays
//   high if the pending result leaves in the same cycle, so a stalled
//   receiver holds back at most one item.
`timescale 1ns / 1ps

`include "stepper_homing_position_controller_assert.svh"

module stepper_homing_position_controller (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [7:0] cfg_wdata,
	shpc_req_if.sink req,
	shpc_rsp_if.source rsp
);

	logic [7:0] offset_steps_q;
	shpc_pkg::ctrl_state_t state_q;
	shpc_pkg::ctrl_state_t state_nxt;
	logic [1:0] step_dir;
	shpc_pkg::result_t rsp_q;
	logic rsp_vld_q;
	logic accept;

	assign req.ready = !rsp_vld_q || rsp.ready;
	assign accept = req.valid && req.ready;

	shpc_step u_step (
		.mode(req.mode),
		.detector_active(req.detector_active),
		.target_position(req.target_position),
		.offset_steps(offset_steps_q),
		.cur(state_q),
		.nxt(state_nxt),
		.step_dir(step_dir)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_steps_q <= shpc_pkg::OFFSET_RESET;
		end else if (cfg_we) begin
			offset_steps_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase <= shpc_pkg::PH_CALIB;
			state_q.cur_pos <= '0;
			state_q.des_pos <= '0;
			rsp_vld_q <= 1'b0;
		end else begin
			if (accept) begin
				state_q <= state_nxt;
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.step_dir <= step_dir;
			rsp_q.phase <= shpc_pkg::phase_code(state_nxt.phase);
			rsp_q.position <= shpc_pkg::OUT_POS_BITS'(state_nxt.cur_pos);
		end
	end

	assign rsp.valid = rsp_vld_q;
	assign rsp.step_dir = rsp_q.step_dir;
	assign rsp.phase = rsp_q.phase;
	assign rsp.position = rsp_q.position;

	`SHPC_ASSERT_NEXT(a_accept_gives_result, accept, rsp.valid, "accepted item gave no result")
	`SHPC_ASSERT_NEXT(a_no_step_off_tick, accept && (req.mode != shpc_pkg::MODE_TICK), rsp.step_dir == shpc_pkg::DIR_NONE, "step issued for a non-tick item")
	`SHPC_ASSERT_NOW(a_right_only_moving, rsp.valid && (rsp.step_dir == shpc_pkg::DIR_RIGHT), rsp.phase == shpc_pkg::PHASE_CODE_MOVING, "right step outside moving phase")

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Testbench for the stepper homing and position controller: directed and random items,
// with offset_steps changed between phases, checked against an in-bench motion predictor.
// Depends on shpc_pkg, shpc_if and the stepper_homing_position_controller RTL.

module tb;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 200000;
	localparam int ROUND_ITEMS = 300;

	class motor_scoreboard;
		logic [1:0] ph;
		logic [shpc_pkg::POS_BITS-1:0] cur_pos;
		logic [shpc_pkg::POS_BITS-1:0] goal_pos;
		logic [7:0] offset_steps;
		shpc_pkg::result_t predicted_steps[$];
		int faults;

		function new();
			ph = shpc_pkg::PHASE_CODE_CALIB;
			cur_pos = '0;
			goal_pos = '0;
			offset_steps = shpc_pkg::OFFSET_RESET;
			faults = 0;
		endfunction

		task report(input string what);
			$display("tb: mismatch: %s", what);
			faults++;
		endtask

		function void apply_item(input logic [1:0] mode, input logic detector,
				input logic [15:0] target);
			shpc_pkg::result_t r;
			r.step_dir = shpc_pkg::DIR_NONE;
			case (mode)
				shpc_pkg::MODE_TICK: begin
					case (ph)
						shpc_pkg::PHASE_CODE_CALIB: begin
							if (detector) begin
								ph = shpc_pkg::PHASE_CODE_OFFSET;
								cur_pos = '0;
								goal_pos = '0;
							end else begin
								r.step_dir = shpc_pkg::DIR_LEFT;
							end
						end
						shpc_pkg::PHASE_CODE_OFFSET: begin
							if (cur_pos < offset_steps) begin
								r.step_dir = shpc_pkg::DIR_LEFT;
								cur_pos = cur_pos + 1'b1;
							end else begin
								ph = shpc_pkg::PHASE_CODE_IDLE;
								cur_pos = '0;
								goal_pos = '0;
							end
						end
						shpc_pkg::PHASE_CODE_IDLE: begin
							if (cur_pos != goal_pos)
								ph = shpc_pkg::PHASE_CODE_MOVING;
						end
						default: begin
							if (cur_pos > goal_pos) begin
								r.step_dir = shpc_pkg::DIR_RIGHT;
								cur_pos = cur_pos - 1'b1;
							end else if (cur_pos < goal_pos) begin
								r.step_dir = shpc_pkg::DIR_LEFT;
								cur_pos = cur_pos + 1'b1;
							end else begin
								ph = shpc_pkg::PHASE_CODE_IDLE;
							end
						end
					endcase
				end
				shpc_pkg::MODE_TARGET: goal_pos = target;
				shpc_pkg::MODE_RECAL: ph = shpc_pkg::PHASE_CODE_CALIB;
				default: ;
			endcase
			r.phase = ph;
			r.position = cur_pos;
			predicted_steps.push_back(r);
		endfunction

		task compare_step(input shpc_pkg::result_t got);
			shpc_pkg::result_t want;
			if (predicted_steps.size() == 0) begin
				report($sformatf("result with none due: dir %0d phase %0d pos %0d",
					got.step_dir, got.phase, got.position));
				return;
			end
			want = predicted_steps.pop_front();
			if (got.step_dir !== want.step_dir)
				report($sformatf("step_dir %0d, due %0d", got.step_dir, want.step_dir));
			if (got.phase !== want.phase)
				report($sformatf("phase %0d, due %0d", got.phase, want.phase));
			if (got.position !== want.position)
				report($sformatf("position %0d, due %0d", got.position, want.position));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [7:0] cfg_wdata;
	int cycles = 0;
	int burst_left = 0;
	bit gaps_on = 1'b1;
	int stall_mode = 0;
	logic [7:0] offset_plan [6] = '{8'd255, 8'd0, 8'd1, 8'd12, 8'd7, 8'd128};
	motor_scoreboard sb;

	shpc_req_if req_ch();
	shpc_rsp_if rsp_ch();

	stepper_homing_position_controller i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// receiver: check accepted results, stall on a changing pattern
	always @(posedge clk) begin
		if (rsp_ch.valid && rsp_ch.ready)
			sb.compare_step(shpc_pkg::result_t'({rsp_ch.step_dir, rsp_ch.phase,
				rsp_ch.position}));
		if (cycles % 97 == 0)
			stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: rsp_ch.ready <= 1'b1;
			1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
			2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
			default: rsp_ch.ready <= (cycles % 5 < 2);
		endcase
	end

	task automatic send_item(input logic [1:0] mode, input logic detector,
			input logic [15:0] target);
		req_ch.valid <= 1'b1;
		req_ch.mode <= mode;
		req_ch.detector_active <= detector;
		req_ch.target_position <= target;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		sb.apply_item(mode, detector, target);
		if (gaps_on) begin
			if (burst_left == 0) begin
				req_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 8))
					@(posedge clk);
				burst_left = $urandom_range(1, 30);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic settle();
		req_ch.valid <= 1'b0;
		while (sb.predicted_steps.size() != 0)
			@(posedge clk);
		repeat (3)
			@(posedge clk);
	endtask

	task automatic write_offset(input logic [7:0] steps);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= steps;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.offset_steps = steps;
	endtask

	task automatic random_item();
		int pick;
		logic [15:0] target;
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 7) == 0)
			target = 16'($urandom);
		else
			target = 16'($urandom_range(0, 48));
		if (pick < 74)
			send_item(shpc_pkg::MODE_TICK, $urandom_range(0, 3) == 0, 16'($urandom));
		else if (pick < 91)
			send_item(shpc_pkg::MODE_TARGET, 1'($urandom_range(0, 1)), target);
		else if (pick < 96)
			send_item(shpc_pkg::MODE_RECAL, 1'($urandom_range(0, 1)), 16'($urandom));
		else
			send_item(MODE_UNUSED, 1'($urandom_range(0, 1)), 16'($urandom));
	endtask

	initial begin
		sb = new();
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 8'd0;
		req_ch.valid <= 1'b0;
		req_ch.mode <= shpc_pkg::MODE_TICK;
		req_ch.detector_active <= 1'b0;
		req_ch.target_position <= 16'd0;
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// homing with the reset offset, then short moves both ways
		send_item(shpc_pkg::MODE_TICK, 1'b0, 16'h0000);
		send_item(MODE_UNUSED, 1'b1, 16'hFFFF);
		send_item(shpc_pkg::MODE_TARGET, 1'b0, 16'hFFFF);
		send_item(shpc_pkg::MODE_RECAL, 1'b1, 16'h0000);
		send_item(shpc_pkg::MODE_TICK, 1'b1, 16'hAAAA);
		for (int k = 0; k < 13; k++)
			send_item(shpc_pkg::MODE_TICK, k[0], 16'h5555);
		send_item(shpc_pkg::MODE_TICK, 1'b0, 16'h0000);
		send_item(shpc_pkg::MODE_TARGET, 1'b1, 16'h0001);
		repeat (3)
			send_item(shpc_pkg::MODE_TICK, 1'b0, 16'h0000);
		send_item(shpc_pkg::MODE_TARGET, 1'b0, 16'h0000);
		repeat (3)
			send_item(shpc_pkg::MODE_TICK, 1'b0, 16'h0000);

		// lower the offset mid-count: the next tick zeroes and idles
		write_offset(8'd200);
		send_item(shpc_pkg::MODE_RECAL, 1'b0, 16'h0000);
		send_item(shpc_pkg::MODE_TICK, 1'b1, 16'h0000);
		repeat (5)
			send_item(shpc_pkg::MODE_TICK, 1'b0, 16'h0000);
		write_offset(8'd2);
		send_item(shpc_pkg::MODE_TICK, 1'b0, 16'h0000);
		send_item(shpc_pkg::MODE_TICK, 1'b0, 16'h0000);

		for (int round = 0; round < 6; round++) begin
			write_offset(offset_plan[round]);
			gaps_on = (round % 3 != 1);
			repeat (ROUND_ITEMS)
				random_item();
		end

		settle();
		if (sb.faults == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
